/* src/segint_pkg.sv */
package segint_pkg;

  // parallel threshold register
  localparam int unsigned EpsW = 24;
  localparam logic [EpsW-1:0] EpsReset = 24'd1678;

endpackage

/* src/segment_intersection_nearest.sv */
// channel  | dir | signals                               | contents
// s_axis   | in  | tvalid, tready, tdata                 | two segments and previous best
// m_axis   | out | tvalid, tready, tdata, tuser          | new best, wall normal, updated
// cfg      | in  | cfg_valid_i, cfg_ready_o, cfg_data_i  | parallel threshold
//
// one word per cycle in and out while m_axis_tready holds; the pipeline registers are
// edge vectors, products, sums, sign check, PARAM_FRAC_BITS + 1 divider stages and
// output compare, the divider giving one quotient bit per stage
// reset clears all valid bits and loads the threshold with its default
// each stage holds while its successor is full and stalled; bubbles collapse
module segment_intersection_nearest import segint_pkg::*; #(
  parameter int unsigned COORD_BITS      = 24,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, end_x, end_y, wall_start_x, wall_start_y,
  // wall_end_x, wall_end_y, prev_best, zero pad
  input  logic [((8*COORD_BITS+PARAM_FRAC_BITS+2+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // best_param, normal_x, normal_y, zero pad
  output logic [((2*COORD_BITS+PARAM_FRAC_BITS+4+7)/8)*8-1:0] m_axis_tdata,
  // updated
  output logic m_axis_tuser,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [EpsW-1:0] cfg_data_i
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned BW    = PARAM_FRAC_BITS + 2;
  localparam int unsigned QW    = PARAM_FRAC_BITS + 1;
  localparam int unsigned SW    = 2 * CB + 3;
  localparam int unsigned OW    = BW + 2 * (CB + 1);
  localparam int unsigned OPADW = ((OW + 7) / 8) * 8;

  logic [EpsW-1:0] eps_q;

  logic                 f_valid, f_ready;
  logic signed [SW-1:0] f_d, f_sn, f_tn;
  logic signed [CB:0]   f_vx, f_vy;
  logic [BW-1:0]        f_prev;

  logic                 c_valid, c_ready, c_hit;
  logic [SW-1:0]        c_num, c_den;
  logic signed [CB:0]   c_vx, c_vy;
  logic [BW-1:0]        c_prev;

  logic                 q_valid, q_ready, q_hit;
  logic [QW-1:0]        q_quot;
  logic signed [CB:0]   q_vx, q_vy;
  logic [BW-1:0]        q_prev;

  logic                 o_valid_q, upd;
  logic [BW-1:0]        o_best_q;
  logic signed [CB:0]   o_nx_q, o_ny_q;
  logic                 o_upd_q;

  // threshold register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (cfg_valid_i) begin
      eps_q <= cfg_data_i;
    end
  end

  segint_front #(.COORD_BITS(CB), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .start_x_i      (s_axis_tdata[0*CB +: CB]),
    .start_y_i      (s_axis_tdata[1*CB +: CB]),
    .end_x_i        (s_axis_tdata[2*CB +: CB]),
    .end_y_i        (s_axis_tdata[3*CB +: CB]),
    .wall_start_x_i (s_axis_tdata[4*CB +: CB]),
    .wall_start_y_i (s_axis_tdata[5*CB +: CB]),
    .wall_end_x_i   (s_axis_tdata[6*CB +: CB]),
    .wall_end_y_i   (s_axis_tdata[7*CB +: CB]),
    .prev_best_i    (s_axis_tdata[8*CB +: BW]),
    .out_valid_o    (f_valid),
    .out_ready_i    (f_ready),
    .d_o (f_d), .sn_o (f_sn), .tn_o (f_tn),
    .vx_o (f_vx), .vy_o (f_vy), .prev_o (f_prev)
  );

  segint_check #(.COORD_BITS(CB), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_check (
    .clk_i, .rst_ni,
    .eps_i       (eps_q),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .d_i (f_d), .sn_i (f_sn), .tn_i (f_tn),
    .vx_i (f_vx), .vy_i (f_vy), .prev_i (f_prev),
    .out_valid_o (c_valid),
    .out_ready_i (c_ready),
    .hit_o (c_hit), .num_o (c_num), .den_o (c_den),
    .vx_o (c_vx), .vy_o (c_vy), .prev_o (c_prev)
  );

  segint_div #(.COORD_BITS(CB), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_div (
    .clk_i, .rst_ni,
    .in_valid_i  (c_valid),
    .in_ready_o  (c_ready),
    .hit_i (c_hit), .num_i (c_num), .den_i (c_den),
    .vx_i (c_vx), .vy_i (c_vy), .prev_i (c_prev),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .hit_o (q_hit), .quot_o (q_quot),
    .vx_o (q_vx), .vy_o (q_vy), .prev_o (q_prev)
  );

  // nearest compare and output register
  assign q_ready = !o_valid_q || m_axis_tready;
  assign upd     = q_hit && ({1'b0, q_quot} < q_prev);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (q_ready) begin
      o_valid_q <= q_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_ready) begin
      o_best_q <= upd ? {1'b0, q_quot} : q_prev;
      o_nx_q   <= upd ? -q_vy : '0;
      o_ny_q   <= upd ? q_vx : '0;
      o_upd_q  <= upd;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_upd_q;
  assign m_axis_tdata  = OPADW'({o_ny_q, o_nx_q, o_best_q});

  // an update always carries a non-degenerate wall normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (o_nx_q != '0) || (o_ny_q != '0))
    else $error("hit with zero wall normal");

  // no update means zero normals
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (o_nx_q == '0) && (o_ny_q == '0))
    else $error("normal set without update");

  // input back-pressure only when the whole pipe is full behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // an updated best is strictly below the previous one and within range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready && q_valid && upd |=> o_best_q <= BW'(1 << PARAM_FRAC_BITS))
    else $error("updated best out of range");

endmodule

/* src/segint_front.sv */
module segint_front import segint_pkg::*; #(
  parameter int unsigned COORD_BITS      = 24,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_BITS-1:0]      start_x_i,
  input  logic signed [COORD_BITS-1:0]      start_y_i,
  input  logic signed [COORD_BITS-1:0]      end_x_i,
  input  logic signed [COORD_BITS-1:0]      end_y_i,
  input  logic signed [COORD_BITS-1:0]      wall_start_x_i,
  input  logic signed [COORD_BITS-1:0]      wall_start_y_i,
  input  logic signed [COORD_BITS-1:0]      wall_end_x_i,
  input  logic signed [COORD_BITS-1:0]      wall_end_y_i,
  input  logic [PARAM_FRAC_BITS+1:0]        prev_best_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [2*COORD_BITS+2:0]    d_o,
  output logic signed [2*COORD_BITS+2:0]    sn_o,
  output logic signed [2*COORD_BITS+2:0]    tn_o,
  output logic signed [COORD_BITS:0]        vx_o,
  output logic signed [COORD_BITS:0]        vy_o,
  output logic [PARAM_FRAC_BITS+1:0]        prev_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned BW = PARAM_FRAC_BITS + 2;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic signed [DW-1:0] ux_q, uy_q, vx1_q, vy1_q, wx_q, wy_q;
  logic [BW-1:0]        prev1_q, prev2_q, prev3_q;
  logic signed [PW-1:0] p_uxvy_q, p_uyvx_q, p_wxuy_q, p_wyux_q, p_wxvy_q, p_wyvx_q;
  logic signed [DW-1:0] vx2_q, vy2_q, vx3_q, vy3_q;
  logic signed [SW-1:0] d_q, sn_q, tn_q;

  // stage ready chain, bubbles collapse
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 1: edge vectors
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ux_q    <= $signed({end_x_i[COORD_BITS-1], end_x_i})
               - $signed({start_x_i[COORD_BITS-1], start_x_i});
      uy_q    <= $signed({end_y_i[COORD_BITS-1], end_y_i})
               - $signed({start_y_i[COORD_BITS-1], start_y_i});
      vx1_q   <= $signed({wall_end_x_i[COORD_BITS-1], wall_end_x_i})
               - $signed({wall_start_x_i[COORD_BITS-1], wall_start_x_i});
      vy1_q   <= $signed({wall_end_y_i[COORD_BITS-1], wall_end_y_i})
               - $signed({wall_start_y_i[COORD_BITS-1], wall_start_y_i});
      wx_q    <= $signed({wall_start_x_i[COORD_BITS-1], wall_start_x_i})
               - $signed({start_x_i[COORD_BITS-1], start_x_i});
      wy_q    <= $signed({wall_start_y_i[COORD_BITS-1], wall_start_y_i})
               - $signed({start_y_i[COORD_BITS-1], start_y_i});
      prev1_q <= prev_best_i;
    end
  end

  // stage 2: six cross products
  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      p_uxvy_q <= ux_q * vy1_q;
      p_uyvx_q <= uy_q * vx1_q;
      p_wxuy_q <= wx_q * uy_q;
      p_wyux_q <= wy_q * ux_q;
      p_wxvy_q <= wx_q * vy1_q;
      p_wyvx_q <= wy_q * vx1_q;
      vx2_q    <= vx1_q;
      vy2_q    <= vy1_q;
      prev2_q  <= prev1_q;
    end
  end

  // stage 3: denominator and numerators
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      d_q     <= $signed({p_uxvy_q[PW-1], p_uxvy_q}) - $signed({p_uyvx_q[PW-1], p_uyvx_q});
      sn_q    <= $signed({p_wxuy_q[PW-1], p_wxuy_q}) - $signed({p_wyux_q[PW-1], p_wyux_q});
      tn_q    <= $signed({p_wxvy_q[PW-1], p_wxvy_q}) - $signed({p_wyvx_q[PW-1], p_wyvx_q});
      vx3_q   <= vx2_q;
      vy3_q   <= vy2_q;
      prev3_q <= prev2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign d_o         = d_q;
  assign sn_o        = sn_q;
  assign tn_o        = tn_q;
  assign vx_o        = vx3_q;
  assign vy_o        = vy3_q;
  assign prev_o      = prev3_q;

endmodule

/* src/segint_check.sv */
module segint_check import segint_pkg::*; #(
  parameter int unsigned COORD_BITS      = 24,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [EpsW-1:0]                eps_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [2*COORD_BITS+2:0] d_i,
  input  logic signed [2*COORD_BITS+2:0] sn_i,
  input  logic signed [2*COORD_BITS+2:0] tn_i,
  input  logic signed [COORD_BITS:0]     vx_i,
  input  logic signed [COORD_BITS:0]     vy_i,
  input  logic [PARAM_FRAC_BITS+1:0]     prev_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic [2*COORD_BITS+2:0]        num_o,
  output logic [2*COORD_BITS+2:0]        den_o,
  output logic signed [COORD_BITS:0]     vx_o,
  output logic signed [COORD_BITS:0]     vy_o,
  output logic [PARAM_FRAC_BITS+1:0]     prev_o
);

  localparam int unsigned SW = 2 * COORD_BITS + 3;
  localparam int unsigned BW = PARAM_FRAC_BITS + 2;

  logic                 v_q, rdy;
  logic signed [SW-1:0] ad, atn, asn;
  logic                 hit;
  logic                 hit_q;
  logic [SW-1:0]        num_q, den_q;
  logic signed [COORD_BITS:0] vx_q, vy_q;
  logic [BW-1:0]        prev_q;

  assign rdy        = !v_q || out_ready_i;
  assign in_ready_o = rdy;

  // fold the sign of d into both numerators, then range checks
  always_comb begin
    ad  = d_i[SW-1] ? -d_i  : d_i;
    atn = d_i[SW-1] ? -tn_i : tn_i;
    asn = d_i[SW-1] ? -sn_i : sn_i;
    hit = (d_i != '0)
       && ($unsigned(ad) >= {{(SW-EpsW){1'b0}}, eps_i})
       && !atn[SW-1] && (atn <= ad)
       && !asn[SW-1] && (asn <= ad);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      hit_q  <= hit;
      num_q  <= $unsigned(atn);
      den_q  <= $unsigned(ad);
      vx_q   <= vx_i;
      vy_q   <= vy_i;
      prev_q <= prev_i;
    end
  end

  assign out_valid_o = v_q;
  assign hit_o       = hit_q;
  assign num_o       = num_q;
  assign den_o       = den_q;
  assign vx_o        = vx_q;
  assign vy_o        = vy_q;
  assign prev_o      = prev_q;

endmodule

/* src/segint_div.sv */
module segint_div import segint_pkg::*; #(
  parameter int unsigned COORD_BITS      = 24,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           hit_i,
  input  logic [2*COORD_BITS+2:0]        num_i,
  input  logic [2*COORD_BITS+2:0]        den_i,
  input  logic signed [COORD_BITS:0]     vx_i,
  input  logic signed [COORD_BITS:0]     vy_i,
  input  logic [PARAM_FRAC_BITS+1:0]     prev_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic [PARAM_FRAC_BITS:0]       quot_o,
  output logic signed [COORD_BITS:0]     vx_o,
  output logic signed [COORD_BITS:0]     vy_o,
  output logic [PARAM_FRAC_BITS+1:0]     prev_o
);

  localparam int unsigned SW = 2 * COORD_BITS + 3;
  localparam int unsigned BW = PARAM_FRAC_BITS + 2;
  localparam int unsigned QW = PARAM_FRAC_BITS + 1;
  localparam int unsigned NS = PARAM_FRAC_BITS + 1;

  logic                       v_q    [NS];
  logic                       rdy    [NS];
  logic                       hit_q  [NS];
  logic [SW-1:0]              r_q    [NS];
  logic [SW-1:0]              den_q  [NS];
  logic [QW-1:0]              q_q    [NS];
  logic signed [COORD_BITS:0] vx_q   [NS];
  logic signed [COORD_BITS:0] vy_q   [NS];
  logic [BW-1:0]              prev_q [NS];

  assign in_ready_o = rdy[0];

  // one quotient bit per stage: restoring compare and subtract
  for (genvar k = 0; k < NS; k++) begin : g_step
    logic          v_in, hit_in;
    logic [SW:0]   r_sh;
    logic [SW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic signed [COORD_BITS:0] vx_in, vy_in;
    logic [BW-1:0] prev_in;
    logic          bit_d;
    logic [SW-1:0] r_d;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign hit_in  = hit_i;
      assign r_sh    = {1'b0, num_i};
      assign den_in  = den_i;
      assign q_in    = '0;
      assign vx_in   = vx_i;
      assign vy_in   = vy_i;
      assign prev_in = prev_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign hit_in  = hit_q[k-1];
      assign r_sh    = {r_q[k-1], 1'b0};
      assign den_in  = den_q[k-1];
      assign q_in    = q_q[k-1];
      assign vx_in   = vx_q[k-1];
      assign vy_in   = vy_q[k-1];
      assign prev_in = prev_q[k-1];
    end

    if (k == NS - 1) begin : g_last
      assign rdy[k] = !v_q[k] || out_ready_i;
    end else begin : g_mid
      assign rdy[k] = !v_q[k] || rdy[k+1];
    end

    assign bit_d = (r_sh >= {1'b0, den_in});
    assign r_d   = bit_d ? SW'(r_sh - {1'b0, den_in}) : SW'(r_sh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        hit_q[k]  <= hit_in;
        r_q[k]    <= r_d;
        den_q[k]  <= den_in;
        q_q[k]    <= {q_in[QW-2:0], bit_d};
        vx_q[k]   <= vx_in;
        vy_q[k]   <= vy_in;
        prev_q[k] <= prev_in;
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign hit_o       = hit_q[NS-1];
  assign quot_o      = q_q[NS-1];
  assign vx_o        = vx_q[NS-1];
  assign vy_o        = vy_q[NS-1];
  assign prev_o      = prev_q[NS-1];

endmodule
